>>> design/bounded_ordered_list_engine_defines.svh
// Assertion macros shared by the checker of the ordered list engine.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BLE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define BLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

>>> design/ble_pkg.sv
`timescale 1ns / 1ps

package ble_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int VALUE_W       = 32;
   localparam int SCAN_GROUP    = 8;

   typedef enum logic [2:0] {
      OP_APPEND  = 3'd0,
      OP_PREPEND = 3'd1,
      OP_REMOVE  = 3'd2,
      OP_INSERT  = 3'd3,
      OP_DELETE  = 3'd4,
      OP_SEARCH  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_FINISH
   } fsm_type;

   typedef enum logic [1:0] {
      SH_HOLD,
      SH_UP,
      SH_DOWN
   } shift_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      shift_type          mode;
      logic [VALUE_W-1:0] value;
   } cell_cmd_type;

   // Status of the match scanner.
   typedef struct packed {
      logic done;
      logic hit;
   } scan_status_type;

endpackage

>>> design/ble_cell.sv
`timescale 1ns / 1ps

module ble_cell #(
   parameter int CELL_INDEX = 0,
   parameter int IW         = 6
) (
   input  logic                      clock,
   input  ble_pkg::cell_cmd_type     cmd,
   input  logic [IW-1:0]             gap_index,
   input  logic [ble_pkg::VALUE_W-1:0] left_value,
   input  logic [ble_pkg::VALUE_W-1:0] right_value,
   input  logic [ble_pkg::VALUE_W-1:0] key,
   output logic [ble_pkg::VALUE_W-1:0] value_out,
   output logic                      equal
);
   import ble_pkg::*;

   localparam logic [IW-1:0] MY_INDEX = IW'(CELL_INDEX);

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;

   // Opening a gap moves cells above it up by one; closing moves them down.
   always_comb begin
      value_in = value_ff;
      case (cmd.mode)
         SH_UP: begin
            if (MY_INDEX > gap_index) begin
               value_in = left_value;
            end else if (MY_INDEX == gap_index) begin
               value_in = cmd.value;
            end
         end
         SH_DOWN: begin
            if (MY_INDEX >= gap_index) begin
               value_in = right_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;
   assign equal     = (value_ff == key);

endmodule

>>> design/ble_scan.sv
`timescale 1ns / 1ps

module ble_scan #(
   parameter int DEPTH = ble_pkg::DEPTH_DEFAULT,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DEPTH-1:0]         match,
   output ble_pkg::scan_status_type status,
   output logic [CW-1:0]            found
);
   import ble_pkg::*;

   localparam int NG = (DEPTH + SCAN_GROUP - 1) / SCAN_GROUP;
   localparam int VW = NG * SCAN_GROUP;
   localparam int GW = (NG > 1) ? $clog2(NG) : 1;

   logic [VW-1:0] vec_ff, vec_in;
   logic [GW-1:0] grp_ff, grp_in;
   logic [CW-1:0] base_ff, base_in;
   logic [2:0]    first;
   logic          hit;
   logic          last;

   // Lowest set bit of the current group of match bits.
   always_comb begin
      first = 3'd0;
      for (int b = SCAN_GROUP - 1; b >= 0; b--) begin
         if (vec_ff[b]) begin
            first = 3'(b);
         end
      end
   end

   assign hit  = |vec_ff[SCAN_GROUP-1:0];
   assign last = (grp_ff == GW'(NG - 1));

   always_comb begin
      vec_in  = vec_ff >> SCAN_GROUP;
      grp_in  = grp_ff + GW'(1);
      base_in = base_ff + CW'(SCAN_GROUP);
      if (start) begin
         vec_in  = VW'(match);
         grp_in  = '0;
         base_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_ff <= '0;
      end else begin
         grp_ff <= grp_in;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff  <= vec_in;
      base_ff <= base_in;
   end

   assign status.done = hit || last;
   assign status.hit  = hit;
   assign found       = base_ff + CW'(first) + CW'(1);

endmodule

>>> design/bounded_ordered_list_engine.sv
// Ordered list engine: one operation item in, one result item out.
// A non-search item passes from the idle state to the finish state and then into
// the output register; a search first runs the group-serial match scanner over
// 8-entry match groups (1 to ceil(DEPTH/8) of them) until a hit or the last group.
// A new item is taken only in idle, after the last result enters the free output register.
// Reset (synchronous, active high) empties the list; entry cells are not cleared.
`timescale 1ns / 1ps

module bounded_ordered_list_engine #(
   parameter int DEPTH = ble_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // operation[2:0]
   input  logic [71:0] req_tdata,   // data_value[31:0], position[37:32], key[69:38], zero pad
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic [79:0] rsp_tdata    // removed_value[31:0], found_position[37:32],
                                    // entry_count[43:38], empty_flag[44],
                                    // front_value[76:45], zero pad
);
   import ble_pkg::*;

   // Count width holds DEPTH itself; position compares run at the wider width.
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > 6) ? CW : 6;

   // Request fields.
   op_type             req_op;
   logic [VALUE_W-1:0] req_value;
   logic [5:0]         req_position;
   logic [VALUE_W-1:0] req_key;

   assign req_op       = op_type'(req_tuser);
   assign req_value    = req_tdata[31:0];
   assign req_position = req_tdata[37:32];
   assign req_key      = req_tdata[69:38];

   // Control state.
   fsm_type    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Pending result of the item in flight.
   status_type         pend_status_ff, pend_status_in;
   logic [VALUE_W-1:0] pend_removed_ff, pend_removed_in;
   logic [CW-1:0]      pend_found_ff, pend_found_in;

   // Output register payload.
   status_type         out_status_ff, out_status_in;
   logic [VALUE_W-1:0] out_removed_ff, out_removed_in;
   logic [5:0]         out_found_ff, out_found_in;
   logic [5:0]         out_count_ff, out_count_in;
   logic               out_empty_ff, out_empty_in;
   logic [VALUE_W-1:0] out_front_ff, out_front_in;

   // Cell chain interface.
   cell_cmd_type       cmd;
   logic [CW-1:0]      gap_index;
   logic [VALUE_W-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]   cell_equal;
   logic [DEPTH-1:0]   match;

   // Scanner interface.
   logic            scan_start;
   scan_status_type scan_status;
   logic [CW-1:0]   scan_found;

   logic accept;
   logic out_free;
   logic list_empty;
   logic list_full;
   logic pos_ok;
   logic [PW-1:0] pos_ext;
   logic [PW-1:0] cnt_ext;

   assign req_tready = (state_ff == FSM_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign list_empty = (count_ff == '0);
   assign list_full  = (count_ff >= CW'(DEPTH));
   assign pos_ext    = PW'(req_position);
   assign cnt_ext    = PW'(count_ff);
   // Positions run from 1 to the count; adding past the tail is append's job.
   assign pos_ok     = (req_position != 6'd0) && (pos_ext <= cnt_ext);

   // Decode, list update and the sequencing of one item.
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      pend_status_in  = pend_status_ff;
      pend_removed_in = pend_removed_ff;
      pend_found_in   = pend_found_ff;
      cmd.mode        = SH_HOLD;
      cmd.value       = req_value;
      gap_index       = CW'(pos_ext - PW'(1));
      scan_start      = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      out_status_in   = out_status_ff;
      out_removed_in  = out_removed_ff;
      out_found_in    = out_found_ff;
      out_count_in    = out_count_ff;
      out_empty_in    = out_empty_ff;
      out_front_in    = out_front_ff;

      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               pend_status_in  = ST_OK;
               pend_removed_in = '0;
               pend_found_in   = '0;
               state_in        = FSM_FINISH;
               case (req_op)
                  OP_APPEND: begin
                     if (list_full) begin
                        pend_status_in = ST_FULL;
                     end else begin
                        cmd.mode  = SH_UP;
                        gap_index = count_ff;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  OP_PREPEND: begin
                     if (list_full) begin
                        pend_status_in = ST_FULL;
                     end else begin
                        cmd.mode  = SH_UP;
                        gap_index = '0;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  OP_REMOVE: begin
                     if (list_empty) begin
                        pend_status_in = ST_EMPTY;
                     end else begin
                        pend_removed_in = cell_value[0];
                        cmd.mode        = SH_DOWN;
                        gap_index       = '0;
                        count_in        = count_ff - CW'(1);
                     end
                  end
                  OP_INSERT: begin
                     if (list_empty) begin
                        pend_status_in = ST_EMPTY;
                     end else if (!pos_ok) begin
                        pend_status_in = ST_RANGE;
                     end else if (list_full) begin
                        pend_status_in = ST_FULL;
                     end else begin
                        cmd.mode = SH_UP;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_DELETE: begin
                     if (list_empty) begin
                        pend_status_in = ST_EMPTY;
                     end else if (!pos_ok) begin
                        pend_status_in = ST_RANGE;
                     end else begin
                        cmd.mode = SH_DOWN;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  OP_SEARCH: begin
                     if (list_empty) begin
                        pend_status_in = ST_EMPTY;
                     end else begin
                        scan_start = 1'b1;
                        state_in   = FSM_SCAN;
                     end
                  end
                  default: pend_status_in = ST_OK;
               endcase
            end
         end
         FSM_SCAN: begin
            if (scan_status.done) begin
               pend_found_in = scan_status.hit ? scan_found : '0;
               state_in      = FSM_FINISH;
            end
         end
         FSM_FINISH: begin
            // The chain has settled; count and front come from the new state.
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               out_status_in  = pend_status_ff;
               out_removed_in = pend_removed_ff;
               out_found_in   = 6'(pend_found_ff);
               out_count_in   = 6'(count_ff);
               out_empty_in   = list_empty;
               out_front_in   = list_empty ? '0 : cell_value[0];
               state_in       = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff  <= pend_status_in;
      pend_removed_ff <= pend_removed_in;
      pend_found_ff   <= pend_found_in;
      out_status_ff   <= out_status_in;
      out_removed_ff  <= out_removed_in;
      out_found_ff    <= out_found_in;
      out_count_ff    <= out_count_in;
      out_empty_ff    <= out_empty_in;
      out_front_ff    <= out_front_in;
   end

   // The chain: each cell holds one list slot and trades with its neighbors.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_W-1:0] left_value;
      logic [VALUE_W-1:0] right_value;

      if (i == 0) begin : g_head
         assign left_value = '0;
      end else begin : g_left
         assign left_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_value = '0;
      end else begin : g_right
         assign right_value = cell_value[i+1];
      end

      ble_cell #(
         .CELL_INDEX (i),
         .IW         (CW)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .gap_index   (gap_index),
         .left_value  (left_value),
         .right_value (right_value),
         .key         (req_key),
         .value_out   (cell_value[i]),
         .equal       (cell_equal[i])
      );

      // Only slots below the count take part in a search.
      assign match[i] = cell_equal[i] && (CW'(i) < count_ff);
   end

   ble_scan #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .start  (scan_start),
      .match  (match),
      .status (scan_status),
      .found  (scan_found)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {3'b000, out_front_ff, out_empty_ff, out_count_ff,
                        out_found_ff, out_removed_ff};

endmodule

>>> design/ble_checker.sv
`timescale 1ns / 1ps
`include "bounded_ordered_list_engine_defines.svh"

module ble_checker #(
   parameter int DEPTH = ble_pkg::DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [2:0]  req_tuser,
   input logic [71:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [1:0]  rsp_tuser,
   input logic [79:0] rsp_tdata
);
   import ble_pkg::*;

   // Count-based checks only hold while the count fits its 6-bit field.
   localparam bit NARROW = (DEPTH <= 63);

   logic [5:0]  rsp_found;
   logic [5:0]  rsp_count;
   logic        rsp_empty;
   logic [31:0] rsp_front;
   logic        req_seen;

   assign rsp_found = rsp_tdata[37:32];
   assign rsp_count = rsp_tdata[43:38];
   assign rsp_empty = rsp_tdata[44];
   assign rsp_front = rsp_tdata[76:45];
   assign req_seen  = req_tvalid && req_tready && (req_tuser != 3'd7)
                      && (req_tdata[71:70] == 2'b00);

   // A stalled result holds.
   `BLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // The empty flag and the count agree, and an empty list shows no front.
   `BLE_ASSERT_IMPLY(a_empty_count, clock, reset, rsp_tvalid && NARROW, rsp_empty == (rsp_count == 6'd0))
   `BLE_ASSERT_IMPLY(a_empty_front, clock, reset, rsp_tvalid && rsp_empty, rsp_front == 32'd0)

   // A found position lies inside the list and comes with a good status.
   `BLE_ASSERT_IMPLY(a_found_range, clock, reset, rsp_tvalid && NARROW && (rsp_found != 6'd0), (rsp_found <= rsp_count) && (rsp_tuser == ST_OK))

   // An accepted item is never answered in the very next cycle.
   `BLE_ASSERT_NEXT(a_no_early, clock, reset, req_seen && !rsp_tvalid, !rsp_tvalid)

endmodule

bind bounded_ordered_list_engine ble_checker #(.DEPTH(DEPTH)) u_checker (.*);
